// ===== hdl/stt_pkg.sv =====
// Shared types and constants for the script tokenizer.
package stt_pkg;

  localparam int MAX_TOKEN  = 256;
  localparam int LEN_W      = $clog2(MAX_TOKEN + 1);
  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam logic [15:0] LINE_FIRST = 16'd1;
  localparam logic [15:0] LINE_MAX   = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_BYTE         = 3'd0,
    KIND_TOKEN_END    = 3'd1,
    KIND_TEXT_END     = 3'd2,
    KIND_UNTERMINATED = 3'd3,
    KIND_TOO_LONG     = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_BSTAR  = 3'd4,
    MODE_QUOTED = 3'd5,
    MODE_WORD   = 3'd6,
    MODE_DRAIN  = 3'd7
  } mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  token_byte;
    logic [15:0] line_number;
    logic        last_of_input;
  } res_t;

endpackage

// ===== hdl/stt_ifs.sv =====
// Valid/ready channel interfaces for script bytes and tokenizer results.
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface stt_out_if;
  logic                valid;
  logic                ready;
  stt_pkg::kind_t      kind;
  logic [7:0]          token_byte;
  logic [15:0]         line_number;
  logic                last_of_input;

  modport source (output valid, output kind, output token_byte, output line_number,
                  output last_of_input, input ready);
  modport sink   (input valid, input kind, input token_byte, input line_number,
                  input last_of_input, output ready);
endinterface

// ===== hdl/script_tokenizer_with_comments.sv =====
// Script tokenizer: comment skipping, token byte stream and line tracking.
//
// in_chan carries one script byte per beat; byte 0 ends the text. out_chan
// carries result beats: token bytes, token ends, end of text and errors,
// each tagged with the current line and a flag on the last beat of a byte.
// Every accepted byte is decoded in the cycle it is taken; its zero to three
// results enter a four-entry result queue and are offered on out_chan from
// the queue registers, after any results queued before them. One byte is
// taken per cycle while the queue holds at most one result; a byte yielding
// three results (a lone slash before end of text) can leave the queue too
// full to take the next byte until it drains.
// When the receiver stalls, queued results hold and in_chan.ready drops once
// fewer than three entries are free, resuming as the queue drains.
// Synchronous active-low reset empties the queue, returns to idle between
// tokens, clears the token length and sets the line counter to one.
module script_tokenizer_with_comments (
  input logic          clk,
  input logic          rst_n,
  stt_in_if.sink       in_chan,
  stt_out_if.source    out_chan
);
  import stt_pkg::*;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       tbyte;
    logic [LEN_W-1:0] len;
    logic             drain;
  } tok_t;

  function automatic tok_t tok_step(input logic [LEN_W-1:0] len, input logic [7:0] c);
    tok_t       t;
    logic [LEN_W:0] inc;
    inc = {1'b0, len} + (LEN_W + 1)'(1);
    if (inc >= (LEN_W + 1)'(MAX_TOKEN)) begin
      t.kind  = KIND_TOO_LONG;
      t.tbyte = CH_NUL;
      t.len   = '0;
      t.drain = 1'b1;
    end else begin
      t.kind  = KIND_BYTE;
      t.tbyte = c;
      t.len   = inc[LEN_W-1:0];
      t.drain = 1'b0;
    end
    return t;
  endfunction

  mode_t            mode_r, mode_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [15:0]      line_r, line_nxt;
  logic [15:0]      line_inc;

  res_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  kind_t            res_kind [MAX_RES];
  logic [7:0]       res_byte [MAX_RES];
  logic [1:0]       push_n;
  logic             in_fire, out_fire;
  logic [7:0]       c;
  logic             is_ws;
  tok_t             t;

  assign c         = in_chan.ch;
  assign is_ws     = (c != CH_NUL) && (c <= CH_SPACE);
  assign line_inc  = (line_r != LINE_MAX) ? line_r + 16'd1 : line_r;
  assign in_chan.ready = (count_r <= CNT_W'(FIFO_DEPTH - MAX_RES));
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign out_fire  = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      len_r  <= '0;
      line_r <= LINE_FIRST;
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      line_r <= line_nxt;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    line_nxt = line_r;
    push_n   = 2'd0;
    t        = tok_step(len_r, c);
    for (int i = 0; i < MAX_RES; i++) begin
      res_kind[i] = KIND_BYTE;
      res_byte[i] = CH_NUL;
    end
    case (mode_r)
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          mode_nxt = MODE_LINE;
        end else if (c == CH_STAR) begin
          mode_nxt = MODE_BSTAR;
        end else begin
          res_kind[0] = KIND_BYTE;
          res_byte[0] = CH_SLASH;
          if (c > CH_SPACE) begin
            t           = tok_step(LEN_W'(1), c);
            res_kind[1] = t.kind;
            res_byte[1] = t.tbyte;
            push_n      = 2'd2;
            len_nxt     = t.len;
            mode_nxt    = t.drain ? MODE_DRAIN : MODE_WORD;
          end else begin
            res_kind[1] = KIND_TOKEN_END;
            mode_nxt    = MODE_IDLE;
            len_nxt     = '0;
            if (c == CH_NUL) begin
              res_kind[2] = KIND_TEXT_END;
              push_n      = 2'd3;
              line_nxt    = LINE_FIRST;
            end else begin
              push_n = 2'd2;
              if (c == CH_NL) line_nxt = line_inc;
            end
          end
        end
      end
      MODE_LINE: begin
        if (c == CH_NUL) begin
          res_kind[0] = KIND_TEXT_END;
          push_n      = 2'd1;
          mode_nxt    = MODE_IDLE;
          len_nxt     = '0;
          line_nxt    = LINE_FIRST;
        end else if (c == CH_NL) begin
          mode_nxt = MODE_IDLE;
          line_nxt = line_inc;
        end
      end
      MODE_BLOCK, MODE_BSTAR, MODE_DRAIN: begin
        if (c == CH_NUL) begin
          res_kind[0] = KIND_TEXT_END;
          push_n      = 2'd1;
          mode_nxt    = MODE_IDLE;
          len_nxt     = '0;
          line_nxt    = LINE_FIRST;
        end else if (mode_r == MODE_BLOCK) begin
          if (c == CH_STAR) mode_nxt = MODE_BSTAR;
        end else if (mode_r == MODE_BSTAR) begin
          if (c == CH_SLASH) begin
            mode_nxt = MODE_IDLE;
          end else if (c != CH_STAR) begin
            mode_nxt = MODE_BLOCK;
          end
        end
      end
      MODE_QUOTED: begin
        if (c == CH_NUL) begin
          res_kind[0] = KIND_UNTERMINATED;
          res_kind[1] = KIND_TEXT_END;
          push_n      = 2'd2;
          mode_nxt    = MODE_IDLE;
          len_nxt     = '0;
          line_nxt    = LINE_FIRST;
        end else if (c == CH_QUOTE) begin
          res_kind[0] = KIND_TOKEN_END;
          push_n      = 2'd1;
          mode_nxt    = MODE_IDLE;
          len_nxt     = '0;
        end else begin
          res_kind[0] = t.kind;
          res_byte[0] = t.tbyte;
          push_n      = 2'd1;
          len_nxt     = t.len;
          if (t.drain) mode_nxt = MODE_DRAIN;
        end
      end
      MODE_WORD: begin
        if (c > CH_SPACE) begin
          res_kind[0] = t.kind;
          res_byte[0] = t.tbyte;
          push_n      = 2'd1;
          len_nxt     = t.len;
          if (t.drain) mode_nxt = MODE_DRAIN;
        end else begin
          res_kind[0] = KIND_TOKEN_END;
          mode_nxt    = MODE_IDLE;
          len_nxt     = '0;
          if (c == CH_NUL) begin
            res_kind[1] = KIND_TEXT_END;
            push_n      = 2'd2;
            line_nxt    = LINE_FIRST;
          end else begin
            push_n = 2'd1;
            if (c == CH_NL) line_nxt = line_inc;
          end
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        if (c == CH_NUL) begin
          res_kind[0] = KIND_TEXT_END;
          push_n      = 2'd1;
          len_nxt     = '0;
          line_nxt    = LINE_FIRST;
        end else if (is_ws) begin
          if (c == CH_NL) line_nxt = line_inc;
        end else if (c == CH_SLASH) begin
          mode_nxt = MODE_SLASH;
        end else if (c == CH_QUOTE) begin
          mode_nxt = MODE_QUOTED;
          len_nxt  = '0;
        end else begin
          t           = tok_step('0, c);
          res_kind[0] = t.kind;
          res_byte[0] = t.tbyte;
          push_n      = 2'd1;
          len_nxt     = t.len;
          mode_nxt    = t.drain ? MODE_DRAIN : MODE_WORD;
        end
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (in_fire) count_nxt = count_nxt + CNT_W'(push_n);
    if (out_fire) count_nxt = count_nxt - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      if (out_fire) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (2'(i) < push_n) begin
          fifo_r[wr_ptr_r + PTR_W'(i)] <= '{kind:          res_kind[i],
                                           token_byte:    res_byte[i],
                                           line_number:   line_r,
                                           last_of_input: (2'(i) == push_n - 2'd1)};
        end
      end
    end
  end

  assign out_chan.valid         = (count_r != '0);
  assign out_chan.kind          = fifo_r[rd_ptr_r].kind;
  assign out_chan.token_byte    = fifo_r[rd_ptr_r].token_byte;
  assign out_chan.line_number   = fifo_r[rd_ptr_r].line_number;
  assign out_chan.last_of_input = fifo_r[rd_ptr_r].last_of_input;

endmodule

// ===== hdl/stt_checker.sv =====
// Port-level assertions for the script tokenizer, bound to the top level.
module stt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_ready,
  input stt_pkg::kind_t out_kind,
  input logic [7:0]     out_token_byte,
  input logic [15:0]    out_line_number,
  input logic           out_last
);
  import stt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_BYTE || out_kind == KIND_TOKEN_END ||
                   out_kind == KIND_TEXT_END || out_kind == KIND_UNTERMINATED ||
                   out_kind == KIND_TOO_LONG))
    else $error("result kind out of range");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BYTE |-> out_token_byte == 8'h00)
    else $error("non-byte result carries a token byte");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_number != 16'd0)
    else $error("line number is zero");

  a_text_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TEXT_END |-> out_last)
    else $error("end of text is not the last beat of its byte");

endmodule

bind script_tokenizer_with_comments stt_checker u_stt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_kind        (out_chan.kind),
  .out_token_byte  (out_chan.token_byte),
  .out_line_number (out_chan.line_number),
  .out_last        (out_chan.last_of_input)
);
